FILE: rtl/x86e_pkg.sv
// ----------------------------------------------------------------------------
// x86e_pkg: shared types and constants of the instruction encoder.
// Holds the opcode selector codes and the encoded byte-run record.
// ----------------------------------------------------------------------------
package x86e_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW     = 4;

  // Instruction selector codes, in table order.
  typedef enum logic [5:0] {
    OP_MOV_RR = 6'd0, OP_MOV_RI32 = 6'd1, OP_MOV_RI64 = 6'd2, OP_MOV_LD = 6'd3,
    OP_MOV_ST = 6'd4, OP_LEA_RIP = 6'd5, OP_ADD = 6'd6, OP_SUB = 6'd7,
    OP_IMUL = 6'd8, OP_IDIV = 6'd9, OP_DIV = 6'd10, OP_CQO = 6'd11,
    OP_ADD_I = 6'd12, OP_SUB_I = 6'd13, OP_NEG = 6'd14, OP_AND = 6'd15,
    OP_OR = 6'd16, OP_XOR = 6'd17, OP_TEST = 6'd18, OP_NOT = 6'd19,
    OP_SHL_CL = 6'd20, OP_SHR_CL = 6'd21, OP_SAR_CL = 6'd22, OP_SHL_I = 6'd23,
    OP_SHR_I = 6'd24, OP_SAR_I = 6'd25, OP_CMP = 6'd26, OP_CMP_I = 6'd27,
    OP_SETCC = 6'd28, OP_MOVZX_RR = 6'd29, OP_MOVZX_LD = 6'd30, OP_MOV_ST8 = 6'd31,
    OP_MOVSD_LD = 6'd32, OP_MOVSD_ST = 6'd33, OP_ADDSD = 6'd34, OP_SUBSD = 6'd35,
    OP_MULSD = 6'd36, OP_DIVSD = 6'd37, OP_UCOMISD = 6'd38, OP_CVTSI2SD = 6'd39,
    OP_CVTTSD2SI = 6'd40, OP_ROUNDSD = 6'd41, OP_SQRTSD = 6'd42, OP_PUSH = 6'd43,
    OP_POP = 6'd44, OP_JMP = 6'd45, OP_JCC = 6'd46, OP_CALL = 6'd47,
    OP_CALL_R = 6'd48, OP_RET = 6'd49, OP_NOP = 6'd50, OP_INT3 = 6'd51,
    OP_UD2 = 6'd52
  } op_t;

  // One encoded instruction: bytes in emission order, their count and the unused-selector flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     bad;
  } enc_t;

endpackage

FILE: rtl/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder: streams the machine bytes of x86-64 instructions.
//
// The slave side takes one instruction per beat: selector, two register
// numbers, condition nibble, immediate and displacement. The master side
// gives one code byte per beat, with tlast on the final byte of each
// instruction and tuser set when the selector is unused (byte 0x90).
// An accepted instruction is encoded into a byte buffer; its first byte
// appears the cycle after acceptance. The block emits one byte per cycle
// while the receiver is ready, so an instruction of N bytes (1 to 10)
// gives N output beats; the single output port sets the rate. The next
// instruction is taken in the cycle its predecessor's last byte leaves,
// so runs of instructions stream with no gap. When the receiver stalls,
// the current byte holds and the input is not taken. Reset empties the buffer.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder import x86e_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[5:0], reg_a[9:6], reg_b[13:10], cond[17:14], imm[81:18], disp[113:82]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // code_byte[7:0]
  output logic [7:0]   m_tdata,
  output logic         m_tlast,
  // bad_op
  output logic         m_tuser
);

  enc_t            enc_new, buf_q;
  logic [CntW-1:0] pos;
  logic            full;
  logic            in_fire, out_fire, at_last;

  x86e_form u_form (
    .op    (s_tdata[5:0]),
    .reg_a (s_tdata[9:6]),
    .reg_b (s_tdata[13:10]),
    .cond  (s_tdata[17:14]),
    .imm   (s_tdata[81:18]),
    .disp  (s_tdata[113:82]),
    .enc   (enc_new)
  );

  assign at_last  = (pos == buf_q.cnt - 4'd1);
  assign out_fire = m_tvalid & m_tready;
  assign s_tready = ~full | (out_fire & at_last);
  assign in_fire  = s_tvalid & s_tready;

  assign m_tvalid = full;
  assign m_tdata  = buf_q.bytes[pos];
  assign m_tlast  = at_last;
  assign m_tuser  = buf_q.bad;

  // Buffer load and byte pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      pos  <= '0;
    end else if (in_fire) begin
      full  <= 1'b1;
      pos   <= '0;
      buf_q <= enc_new;
    end else if (out_fire) begin
      if (at_last) begin
        full <= 1'b0;
      end
      pos <= pos + 4'd1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    full |-> (buf_q.cnt != 4'd0 && buf_q.cnt <= 4'd10 && pos < buf_q.cnt))
    else $error("byte pointer out of range");
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    (full && buf_q.bad) |-> (m_tlast && m_tdata == 8'h90))
    else $error("unused selector must give one nop byte");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(pos)))
    else $error("stalled byte moved");

endmodule

FILE: rtl/x86e_form.sv
// ----------------------------------------------------------------------------
// x86e_form: combinational instruction former.
// Builds the full byte run of one instruction from its operands.
// ----------------------------------------------------------------------------
module x86e_form import x86e_pkg::*; (
  input  logic [5:0]  op,
  input  logic [3:0]  reg_a,
  input  logic [3:0]  reg_b,
  input  logic [3:0]  cond,
  input  logic [63:0] imm,
  input  logic [31:0] disp,
  output enc_t        enc
);

  function automatic logic [7:0] rex(input logic w, input logic [3:0] r,
                                     input logic [3:0] b);
    rex = {4'h4, w, r[3], 1'b0, b[3]};
  endfunction

  function automatic logic [7:0] mrm(input logic [1:0] md, input logic [2:0] r,
                                     input logic [2:0] m);
    mrm = {md, r, m};
  endfunction

  logic [7:0] bt [MaxBytes];
  logic [CntW-1:0] n;
  logic       bad;
  logic [7:0] d0, d1, d2, d3;
  logic       sib, rbp, xrex;

  assign d0 = disp[7:0];
  assign d1 = disp[15:8];
  assign d2 = disp[23:16];
  assign d3 = disp[31:24];
  assign sib  = (reg_b[2:0] == 3'd4);
  assign rbp  = (reg_b[2:0] == 3'd5);
  assign xrex = reg_a[3] | reg_b[3];

  // Opcode byte of the plain register, extension and memory forms, then the SSE opcode and prefix.
  always_comb begin
    logic [7:0] opc, sopc, spfx;
    logic [2:0] ext;
    logic [CntW-1:0] p;
    for (int i = 0; i < MaxBytes; i++) bt[i] = 8'h00;
    n = '0;
    opc = 8'h00; sopc = 8'h00; spfx = 8'hF2; ext = 3'd0; p = '0;
    bad = 1'b0;
    case (op)
      OP_MOV_RR: opc = 8'h89;
      OP_ADD: opc = 8'h01;
      OP_SUB: opc = 8'h29;
      OP_AND: opc = 8'h21;
      OP_OR: opc = 8'h09;
      OP_XOR: opc = 8'h31;
      OP_TEST: opc = 8'h85;
      OP_CMP: opc = 8'h39;
      OP_MOV_RI32: begin opc = 8'hC7; ext = 3'd0; end
      OP_IDIV: begin opc = 8'hF7; ext = 3'd7; end
      OP_DIV: begin opc = 8'hF7; ext = 3'd6; end
      OP_NEG: begin opc = 8'hF7; ext = 3'd3; end
      OP_NOT: begin opc = 8'hF7; ext = 3'd2; end
      OP_ADD_I: begin opc = 8'h81; ext = 3'd0; end
      OP_SUB_I: begin opc = 8'h81; ext = 3'd5; end
      OP_CMP_I: begin opc = 8'h81; ext = 3'd7; end
      OP_SHL_CL: begin opc = 8'hD3; ext = 3'd4; end
      OP_SHR_CL: begin opc = 8'hD3; ext = 3'd5; end
      OP_SAR_CL: begin opc = 8'hD3; ext = 3'd7; end
      OP_SHL_I: begin opc = 8'hC1; ext = 3'd4; end
      OP_SHR_I: begin opc = 8'hC1; ext = 3'd5; end
      OP_SAR_I: begin opc = 8'hC1; ext = 3'd7; end
      OP_MOV_LD: opc = 8'h8B;
      OP_MOV_ST: opc = 8'h89;
      default: opc = 8'h00;
    endcase
    case (op)
      OP_MOVSD_LD: sopc = 8'h10;
      OP_MOVSD_ST: sopc = 8'h11;
      OP_ADDSD: sopc = 8'h58;
      OP_SUBSD: sopc = 8'h5C;
      OP_MULSD: sopc = 8'h59;
      OP_DIVSD: sopc = 8'h5E;
      OP_UCOMISD: begin sopc = 8'h2E; spfx = 8'h66; end
      OP_CVTSI2SD: sopc = 8'h2A;
      OP_CVTTSD2SI: sopc = 8'h2C;
      OP_SQRTSD: sopc = 8'h51;
      default: sopc = 8'h00;
    endcase

    // Assemble the run for each instruction shape.
    case (op)
      OP_MOV_RR, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_TEST, OP_CMP: begin
        bt[0] = rex(1'b1, reg_b, reg_a); bt[1] = opc;
        bt[2] = mrm(2'd3, reg_b[2:0], reg_a[2:0]); n = 4'd3;
      end
      OP_IDIV, OP_DIV, OP_NEG, OP_NOT, OP_SHL_CL, OP_SHR_CL, OP_SAR_CL: begin
        bt[0] = rex(1'b1, 4'd0, reg_a); bt[1] = opc;
        bt[2] = mrm(2'd3, ext, reg_a[2:0]); n = 4'd3;
      end
      OP_MOV_RI32, OP_ADD_I, OP_SUB_I, OP_CMP_I: begin
        bt[0] = rex(1'b1, 4'd0, reg_a); bt[1] = opc;
        bt[2] = mrm(2'd3, ext, reg_a[2:0]);
        bt[3] = imm[7:0]; bt[4] = imm[15:8]; bt[5] = imm[23:16]; bt[6] = imm[31:24];
        n = 4'd7;
      end
      OP_SHL_I, OP_SHR_I, OP_SAR_I: begin
        bt[0] = rex(1'b1, 4'd0, reg_a); bt[1] = opc;
        bt[2] = mrm(2'd3, ext, reg_a[2:0]); bt[3] = imm[7:0]; n = 4'd4;
      end
      OP_MOV_RI64: begin
        bt[0] = rex(1'b1, 4'd0, reg_a); bt[1] = {5'b10111, reg_a[2:0]};
        for (int i = 0; i < 8; i++) bt[2+i] = imm[8*i +: 8];
        n = 4'd10;
      end
      OP_MOV_LD, OP_MOV_ST: begin
        bt[0] = rex(1'b1, reg_a, reg_b); bt[1] = opc;
        if (sib) begin
          bt[2] = mrm(2'd2, reg_a[2:0], 3'd4); bt[3] = 8'h24;
          bt[4] = d0; bt[5] = d1; bt[6] = d2; bt[7] = d3; n = 4'd8;
        end else begin
          bt[2] = mrm(2'd2, reg_a[2:0], reg_b[2:0]);
          bt[3] = d0; bt[4] = d1; bt[5] = d2; bt[6] = d3; n = 4'd7;
        end
      end
      OP_LEA_RIP: begin
        bt[0] = rex(1'b1, reg_a, 4'd0); bt[1] = 8'h8D;
        bt[2] = mrm(2'd0, reg_a[2:0], 3'd5);
        bt[3] = d0; bt[4] = d1; bt[5] = d2; bt[6] = d3; n = 4'd7;
      end
      OP_IMUL, OP_MOVZX_RR: begin
        bt[0] = rex(1'b1, reg_a, reg_b); bt[1] = 8'h0F;
        bt[2] = (op == OP_IMUL) ? 8'hAF : 8'hB6;
        bt[3] = mrm(2'd3, reg_a[2:0], reg_b[2:0]); n = 4'd4;
      end
      OP_CQO: begin bt[0] = 8'h48; bt[1] = 8'h99; n = 4'd2; end
      OP_SETCC: begin
        bt[0] = rex(1'b0, 4'd0, reg_a); bt[1] = 8'h0F; bt[2] = {4'h9, cond};
        bt[3] = mrm(2'd3, 3'd0, reg_a[2:0]); n = 4'd4;
      end
      OP_MOVZX_LD, OP_MOV_ST8: begin
        if (op == OP_MOVZX_LD) begin
          bt[0] = rex(1'b1, reg_a, reg_b); bt[1] = 8'h0F; bt[2] = 8'hB6; p = 4'd3;
        end else begin
          bt[0] = rex(1'b0, reg_a, reg_b); bt[1] = 8'h88; p = 4'd2;
        end
        if (sib) begin
          bt[p] = mrm(2'd0, reg_a[2:0], 3'd4); bt[p+4'd1] = 8'h24;
          n = p + 4'd2;
        end else if (rbp) begin
          bt[p] = mrm(2'd1, reg_a[2:0], 3'd5); bt[p+4'd1] = 8'h00;
          n = p + 4'd2;
        end else begin
          bt[p] = mrm(2'd0, reg_a[2:0], reg_b[2:0]); n = p + 4'd1;
        end
      end
      OP_MOVSD_LD, OP_MOVSD_ST: begin
        bt[0] = 8'hF2; p = 4'd1;
        if (xrex) begin bt[1] = rex(1'b0, reg_a, reg_b); p = 4'd2; end
        bt[p] = 8'h0F; bt[p+4'd1] = sopc;
        if (sib) begin
          bt[p+4'd2] = mrm(2'd2, reg_a[2:0], 3'd4); bt[p+4'd3] = 8'h24;
          bt[p+4'd4] = d0; bt[p+4'd5] = d1; bt[p+4'd6] = d2; bt[p+4'd7] = d3;
          n = p + 4'd8;
        end else begin
          bt[p+4'd2] = mrm(2'd2, reg_a[2:0], reg_b[2:0]);
          bt[p+4'd3] = d0; bt[p+4'd4] = d1; bt[p+4'd5] = d2; bt[p+4'd6] = d3;
          n = p + 4'd7;
        end
      end
      OP_ADDSD, OP_SUBSD, OP_MULSD, OP_DIVSD, OP_UCOMISD, OP_SQRTSD: begin
        bt[0] = spfx; p = 4'd1;
        if (xrex) begin bt[1] = rex(1'b0, reg_a, reg_b); p = 4'd2; end
        bt[p] = 8'h0F; bt[p+4'd1] = sopc;
        bt[p+4'd2] = mrm(2'd3, reg_a[2:0], reg_b[2:0]); n = p + 4'd3;
      end
      OP_CVTSI2SD, OP_CVTTSD2SI: begin
        bt[0] = 8'hF2; bt[1] = rex(1'b1, reg_a, reg_b); bt[2] = 8'h0F;
        bt[3] = sopc; bt[4] = mrm(2'd3, reg_a[2:0], reg_b[2:0]); n = 4'd5;
      end
      OP_ROUNDSD: begin
        bt[0] = 8'h66; p = 4'd1;
        if (xrex) begin bt[1] = rex(1'b0, reg_a, reg_b); p = 4'd2; end
        bt[p] = 8'h0F; bt[p+4'd1] = 8'h3A; bt[p+4'd2] = 8'h0B;
        bt[p+4'd3] = mrm(2'd3, reg_a[2:0], reg_b[2:0]); bt[p+4'd4] = imm[7:0];
        n = p + 4'd5;
      end
      OP_PUSH, OP_POP: begin
        p = '0;
        if (reg_a[3]) begin bt[0] = 8'h41; p = 4'd1; end
        bt[p] = {4'h5, (op == OP_POP), reg_a[2:0]}; n = p + 4'd1;
      end
      OP_JMP, OP_CALL: begin
        bt[0] = (op == OP_JMP) ? 8'hE9 : 8'hE8;
        bt[1] = d0; bt[2] = d1; bt[3] = d2; bt[4] = d3; n = 4'd5;
      end
      OP_JCC: begin
        bt[0] = 8'h0F; bt[1] = {4'h8, cond};
        bt[2] = d0; bt[3] = d1; bt[4] = d2; bt[5] = d3; n = 4'd6;
      end
      OP_CALL_R: begin
        bt[0] = rex(1'b0, 4'd0, reg_a); bt[1] = 8'hFF;
        bt[2] = mrm(2'd3, 3'd2, reg_a[2:0]); n = 4'd3;
      end
      OP_RET: begin bt[0] = 8'hC3; n = 4'd1; end
      OP_NOP: begin bt[0] = 8'h90; n = 4'd1; end
      OP_INT3: begin bt[0] = 8'hCC; n = 4'd1; end
      OP_UD2: begin bt[0] = 8'h0F; bt[1] = 8'h0B; n = 4'd2; end
      default: begin bt[0] = 8'h90; n = 4'd1; bad = 1'b1; end
    endcase
  end

  // Pack the run into the output record.
  always_comb begin
    for (int i = 0; i < MaxBytes; i++) enc.bytes[i] = bt[i];
    enc.cnt = n;
    enc.bad = bad;
  end

endmodule

FILE: verif/x86e_checker.sv
// ----------------------------------------------------------------------------
// x86e_checker: byte-stream checker for the instruction encoder.
// Watches both channels, works out the machine bytes of every accepted
// instruction and compares each output beat against the oldest expected byte.
// ----------------------------------------------------------------------------
module x86e_checker import x86e_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [7:0]   m_tdata,
  input  logic         m_tlast,
  input  logic         m_tuser,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       bad;
  } byte_exp_t;

  byte_exp_t  byte_q[$];
  logic [7:0] ibuf[$];

  assign pending = byte_q.size();

  function automatic logic [7:0] rex(input logic w, input logic [3:0] r, input logic [3:0] b);
    return {4'h4, w, r[3], 1'b0, b[3]};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] r,
                                       input logic [2:0] m);
    return {md, r, m};
  endfunction

  function automatic void word32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) ibuf.push_back(w[8*i +: 8]);
  endfunction

  // Register-to-register with optional 0F escape.
  function automatic void rr(input logic w, input logic esc, input logic [7:0] opc,
                             input logic [3:0] r, input logic [3:0] m);
    ibuf.push_back(rex(w, r, m));
    if (esc) ibuf.push_back(8'h0F);
    ibuf.push_back(opc);
    ibuf.push_back(modrm(2'd3, r[2:0], m[2:0]));
  endfunction

  // Base plus 32-bit displacement, with SIB when the base is RSP or R12.
  function automatic void mem32(input logic [3:0] r, input logic [3:0] b, input logic [31:0] d);
    if (b[2:0] == 3'd4) begin
      ibuf.push_back(modrm(2'd2, r[2:0], 3'd4));
      ibuf.push_back(8'h24);
    end else begin
      ibuf.push_back(modrm(2'd2, r[2:0], b[2:0]));
    end
    word32(d);
  endfunction

  // Plain base: SIB for RSP/R12, zero disp8 for RBP/R13.
  function automatic void mem0(input logic [3:0] r, input logic [3:0] b);
    if (b[2:0] == 3'd4) begin
      ibuf.push_back(modrm(2'd0, r[2:0], 3'd4));
      ibuf.push_back(8'h24);
    end else if (b[2:0] == 3'd5) begin
      ibuf.push_back(modrm(2'd1, r[2:0], 3'd5));
      ibuf.push_back(8'h00);
    end else begin
      ibuf.push_back(modrm(2'd0, r[2:0], b[2:0]));
    end
  endfunction

  function automatic void sse(input logic [7:0] pfx, input logic [7:0] opc,
                              input logic [3:0] r, input logic [3:0] b, input logic is_mem,
                              input logic [31:0] d);
    ibuf.push_back(pfx);
    if (r[3] | b[3]) ibuf.push_back(rex(1'b0, r, b));
    ibuf.push_back(8'h0F);
    ibuf.push_back(opc);
    if (is_mem) mem32(r, b, d);
    else ibuf.push_back(modrm(2'd3, r[2:0], b[2:0]));
  endfunction

  // Encode one instruction into the expected-byte queue.
  function automatic void encode_instr(input logic [119:0] item);
    logic [5:0]  op;
    logic [3:0]  ra, rb, cc;
    logic [63:0] imm;
    logic [31:0] d;
    logic        bad;
    op  = item[5:0];
    ra  = item[9:6];
    rb  = item[13:10];
    cc  = item[17:14];
    imm = item[81:18];
    d   = item[113:82];
    bad = 1'b0;
    ibuf.delete();
    case (op)
      OP_MOV_RR:    rr(1, 0, 8'h89, rb, ra);
      OP_MOV_RI32:  begin rr(1, 0, 8'hC7, 4'd0, ra); word32(imm[31:0]); end
      OP_MOV_RI64: begin
        ibuf.push_back(rex(1, 4'd0, ra));
        ibuf.push_back(8'hB8 + ra[2:0]);
        word32(imm[31:0]);
        word32(imm[63:32]);
      end
      OP_MOV_LD, OP_MOV_ST: begin
        ibuf.push_back(rex(1, ra, rb));
        ibuf.push_back(op == OP_MOV_LD ? 8'h8B : 8'h89);
        mem32(ra, rb, d);
      end
      OP_LEA_RIP: begin
        ibuf.push_back(rex(1, ra, 4'd0));
        ibuf.push_back(8'h8D);
        ibuf.push_back(modrm(2'd0, ra[2:0], 3'd5));
        word32(d);
      end
      OP_ADD:       rr(1, 0, 8'h01, rb, ra);
      OP_SUB:       rr(1, 0, 8'h29, rb, ra);
      OP_IMUL:      rr(1, 1, 8'hAF, ra, rb);
      OP_IDIV:      rr(1, 0, 8'hF7, 4'd7, ra);
      OP_DIV:       rr(1, 0, 8'hF7, 4'd6, ra);
      OP_CQO:       begin ibuf.push_back(8'h48); ibuf.push_back(8'h99); end
      OP_ADD_I:     begin rr(1, 0, 8'h81, 4'd0, ra); word32(imm[31:0]); end
      OP_SUB_I:     begin rr(1, 0, 8'h81, 4'd5, ra); word32(imm[31:0]); end
      OP_NEG:       rr(1, 0, 8'hF7, 4'd3, ra);
      OP_AND:       rr(1, 0, 8'h21, rb, ra);
      OP_OR:        rr(1, 0, 8'h09, rb, ra);
      OP_XOR:       rr(1, 0, 8'h31, rb, ra);
      OP_TEST:      rr(1, 0, 8'h85, rb, ra);
      OP_NOT:       rr(1, 0, 8'hF7, 4'd2, ra);
      OP_SHL_CL:    rr(1, 0, 8'hD3, 4'd4, ra);
      OP_SHR_CL:    rr(1, 0, 8'hD3, 4'd5, ra);
      OP_SAR_CL:    rr(1, 0, 8'hD3, 4'd7, ra);
      OP_SHL_I:     begin rr(1, 0, 8'hC1, 4'd4, ra); ibuf.push_back(imm[7:0]); end
      OP_SHR_I:     begin rr(1, 0, 8'hC1, 4'd5, ra); ibuf.push_back(imm[7:0]); end
      OP_SAR_I:     begin rr(1, 0, 8'hC1, 4'd7, ra); ibuf.push_back(imm[7:0]); end
      OP_CMP:       rr(1, 0, 8'h39, rb, ra);
      OP_CMP_I:     begin rr(1, 0, 8'h81, 4'd7, ra); word32(imm[31:0]); end
      OP_SETCC:     rr(0, 1, {4'h9, cc}, 4'd0, ra);
      OP_MOVZX_RR:  rr(1, 1, 8'hB6, ra, rb);
      OP_MOVZX_LD: begin
        ibuf.push_back(rex(1, ra, rb));
        ibuf.push_back(8'h0F);
        ibuf.push_back(8'hB6);
        mem0(ra, rb);
      end
      OP_MOV_ST8: begin
        ibuf.push_back(rex(0, ra, rb));
        ibuf.push_back(8'h88);
        mem0(ra, rb);
      end
      OP_MOVSD_LD:  sse(8'hF2, 8'h10, ra, rb, 1, d);
      OP_MOVSD_ST:  sse(8'hF2, 8'h11, ra, rb, 1, d);
      OP_ADDSD:     sse(8'hF2, 8'h58, ra, rb, 0, d);
      OP_SUBSD:     sse(8'hF2, 8'h5C, ra, rb, 0, d);
      OP_MULSD:     sse(8'hF2, 8'h59, ra, rb, 0, d);
      OP_DIVSD:     sse(8'hF2, 8'h5E, ra, rb, 0, d);
      OP_UCOMISD:   sse(8'h66, 8'h2E, ra, rb, 0, d);
      OP_CVTSI2SD:  begin ibuf.push_back(8'hF2); rr(1, 1, 8'h2A, ra, rb); end
      OP_CVTTSD2SI: begin ibuf.push_back(8'hF2); rr(1, 1, 8'h2C, ra, rb); end
      OP_ROUNDSD: begin
        ibuf.push_back(8'h66);
        if (ra[3] | rb[3]) ibuf.push_back(rex(0, ra, rb));
        ibuf.push_back(8'h0F);
        ibuf.push_back(8'h3A);
        ibuf.push_back(8'h0B);
        ibuf.push_back(modrm(2'd3, ra[2:0], rb[2:0]));
        ibuf.push_back(imm[7:0]);
      end
      OP_SQRTSD:    sse(8'hF2, 8'h51, ra, rb, 0, d);
      OP_PUSH, OP_POP: begin
        if (ra[3]) ibuf.push_back(8'h41);
        ibuf.push_back((op == OP_PUSH ? 8'h50 : 8'h58) + ra[2:0]);
      end
      OP_JMP:       begin ibuf.push_back(8'hE9); word32(d); end
      OP_JCC:       begin ibuf.push_back(8'h0F); ibuf.push_back({4'h8, cc}); word32(d); end
      OP_CALL:      begin ibuf.push_back(8'hE8); word32(d); end
      OP_CALL_R: begin
        ibuf.push_back(rex(0, 4'd0, ra));
        ibuf.push_back(8'hFF);
        ibuf.push_back(modrm(2'd3, 3'd2, ra[2:0]));
      end
      OP_RET:       ibuf.push_back(8'hC3);
      OP_NOP:       ibuf.push_back(8'h90);
      OP_INT3:      ibuf.push_back(8'hCC);
      OP_UD2:       begin ibuf.push_back(8'h0F); ibuf.push_back(8'h0B); end
      default:      begin bad = 1'b1; ibuf.push_back(8'h90); end
    endcase
    foreach (ibuf[k]) byte_q.push_back('{ibuf[k], k == ibuf.size() - 1, bad});
  endfunction

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
      byte_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (byte_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected byte %h last %b bad %b", m_tdata, m_tlast, m_tuser);
          errors <= errors + 1;
        end else begin
          byte_exp_t e;
          e = byte_q.pop_front();
          if (e.code !== m_tdata || e.last !== m_tlast || e.bad !== m_tuser) begin
            if (errors < 10)
              $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                       e.code, e.last, e.bad, m_tdata, m_tlast, m_tuser);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) encode_instr(s_tdata);
    end
  end

endmodule

FILE: verif/tb_x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_encoder: stimulus and verdict for the encoder.
// Drives directed instructions for every selector and addressing corner,
// then random instructions with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_x86_64_instruction_encoder import x86e_pkg::*;;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         m_tlast;
  logic         m_tuser;
  int           errors;
  int           pending;
  int           idle_cycles = 0;
  logic         hold_rx = 1'b0;

  always #10 clk = ~clk;

  x86_64_instruction_encoder DUT (.*);

  x86e_checker u_checker (.*);

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: a random wait before each beat, and a
  // hold-off while hold_rx is set.
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, 7);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= ~hold_rx;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) begin
        m_tready <= ~hold_rx;
        @(posedge clk);
      end
    end
  end

  // Offer one instruction; valid drops only during a gap, so beats can follow
  // back to back.
  task automatic send_instr(input logic [5:0] op, input logic [3:0] ra, input logic [3:0] rb,
                            input logic [3:0] cc, input logic [63:0] imm,
                            input logic [31:0] d, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'd0, d, imm, cc, rb, ra, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] rand_disp();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [5:0] op;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: memory bases RSP/R12/RBP/R13, extended registers,
    // field extremes, unused selectors.
    send_instr(OP_MOV_RI64, 4'd15, 4'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0);
    send_instr(OP_MOV_RI64, 4'd0, 4'd0, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOV_LD, 4'd8, 4'd4, 4'd0, 64'h0, 32'h8000_0000, 0);
    send_instr(OP_MOV_ST, 4'd7, 4'd12, 4'd0, 64'h0, 32'h7FFF_FFFF, 0);
    send_instr(OP_MOVZX_LD, 4'd3, 4'd5, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOVZX_LD, 4'd9, 4'd13, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOV_ST8, 4'd2, 4'd4, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOV_ST8, 4'd15, 4'd12, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOV_ST8, 4'd0, 4'd1, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_MOVSD_LD, 4'd15, 4'd12, 4'd0, 64'h0, 32'hFFFF_FFFF, 0);
    send_instr(OP_MOVSD_ST, 4'd1, 4'd2, 4'd0, 64'h0, 32'h1234_5678, 0);
    send_instr(OP_SETCC, 4'd11, 4'd0, 4'd15, 64'h0, 32'h0, 0);
    send_instr(OP_JCC, 4'd0, 4'd0, 4'd0, 64'h0, 32'hFFFF_FFFE, 0);
    send_instr(OP_ROUNDSD, 4'd8, 4'd1, 4'd0, 64'hFF, 32'h0, 0);
    send_instr(OP_PUSH, 4'd12, 4'd0, 4'd0, 64'h0, 32'h0, 0);
    send_instr(OP_POP, 4'd5, 4'd0, 4'd0, 64'h0, 32'h0, 0);
    send_instr(6'd53, 4'd0, 4'd0, 4'd0, 64'h0, 32'h0, 0);
    send_instr(6'd63, 4'd15, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    for (int i = 0; i <= 52; i++)
      send_instr(i[5:0], 4'($urandom), 4'($urandom), 4'($urandom),
                 {$urandom, $urandom}, rand_disp(), 0);

    // Long receiver hold-off while the sender keeps offering.
    hold_rx <= 1'b1;
    fork
      begin repeat (60) @(posedge clk); hold_rx <= 1'b0; end
      for (int i = 0; i < 6; i++)
        send_instr(OP_MOV_RI64, 4'($urandom), 4'd0, 4'd0, {$urandom, $urandom}, 32'h0, 0);
    join
    s_tvalid <= 1'b0;

    // Sender pause until all bytes drained.
    wait (pending == 0);

    // Random part, mostly valid selectors, bursts without gaps mixed in.
    for (int i = 0; i < 150; i++) begin
      op = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(53, 63)) : 6'($urandom_range(0, 52));
      send_instr(op, 4'($urandom), 4'($urandom), 4'($urandom),
                 {$urandom, $urandom}, rand_disp(),
                 (i % 40 < 10) ? 0 : $urandom_range(0, 7));
    end
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/x86e_pkg.sv
rtl/x86e_form.sv
rtl/x86_64_instruction_encoder.sv
verif/x86e_checker.sv
verif/tb_x86_64_instruction_encoder.sv
